>>> rtl/rab_pkg.sv
// shared constants and the beat type handed along the bitmap cell chain
package rab_pkg;

    // stored positions, a whole number of cells
    localparam int DAYS      = 1024;
    localparam int CELL_BITS = 32;
    localparam int NUM_CELLS = DAYS / CELL_BITS;

    // field widths fixed by the interface
    localparam int POS_W   = 11;
    localparam int COUNT_W = 11;

    localparam logic [POS_W-1:0] NUM_DAYS_RESET = POS_W'(DAYS);
    localparam logic [POS_W-1:0] DAYS_POS       = POS_W'(DAYS);
    localparam logic [POS_W-1:0] FIRST_POS      = POS_W'(1);

    // one beat as it moves from cell to cell
    typedef struct packed {
        logic               valid;
        logic [POS_W-1:0]   base;
        logic [POS_W-1:0]   lo;
        logic [POS_W-1:0]   hi;
        logic               mode;
        logic [POS_W-1:0]   lim;
        logic [COUNT_W-1:0] count;
    } beat_t;

endpackage

>>> rtl/rab_cell.sv
// one cell of the chain: a slice of the bitmap, its range update and its share of the count
module rab_cell
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  rab_pkg::beat_t beat_in,
    output rab_pkg::beat_t beat_out
);

    logic [rab_pkg::CELL_BITS-1:0] bits_reg;
    logic [rab_pkg::CELL_BITS-1:0] bits_next;
    logic [rab_pkg::CELL_BITS-1:0] counted;
    logic [rab_pkg::POS_W-1:0]     pos [rab_pkg::CELL_BITS];
    logic                          valid_reg;
    rab_pkg::beat_t                beat_reg;
    rab_pkg::beat_t                beat_next;

    // per-bit range match, new bit value and count mask
    always_comb
    begin
        for (int j = 0; j < rab_pkg::CELL_BITS; j++)
        begin
            pos[j] = beat_in.base + rab_pkg::POS_W'(j + 1);
            if (beat_in.valid && pos[j] >= beat_in.lo && pos[j] <= beat_in.hi)
            begin
                bits_next[j] = beat_in.mode;
            end
            else
            begin
                bits_next[j] = bits_reg[j];
            end
            counted[j] = bits_next[j] && (pos[j] <= beat_in.lim);
        end
    end

    // outgoing beat: next base and running count
    always_comb
    begin
        beat_next       = beat_in;
        beat_next.base  = beat_in.base + rab_pkg::POS_W'(rab_pkg::CELL_BITS);
        beat_next.count = beat_in.count + rab_pkg::COUNT_W'($countones(counted));
    end

    // bitmap slice, all set after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '1;
        end
        else if (en)
        begin
            bits_reg <= bits_next;
        end
    end

    // beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= beat_next.valid;
        end
    end

    // beat payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    // outgoing beat with its registered valid
    always_comb
    begin
        beat_out       = beat_reg;
        beat_out.valid = valid_reg;
    end

endmodule

>>> rtl/range_assign_bitmap_count.sv
// top level: range set/clear over a position bitmap with a running set-bit count
//
// Each beat carries an inclusive range and a mode; mode 1 sets and mode 0 clears the positions
// in the range, clipped to 1..min(num_days, DAYS), and the result beat gives the number of set
// positions in that span after the update. The bitmap is split over a chain of NUM_CELLS cells
// of CELL_BITS positions; a beat walks the chain one cell per cycle while the chain is not held,
// updating each slice and adding its count, so a new beat is taken every cycle unless held;
// each cell and then the output register holds the beat in turn. A stall on the result side
// holds the whole chain. All positions are set after reset; there is no clearing pass. Write
// num_days only while no beat is in flight.
module range_assign_bitmap_count
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rab_pkg::POS_W-1:0]   cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [rab_pkg::POS_W-1:0]   range_low,
    input  logic [rab_pkg::POS_W-1:0]   range_high,
    input  logic                        mode,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [rab_pkg::COUNT_W-1:0] set_count
);

    logic [rab_pkg::POS_W-1:0]   num_days_reg;
    logic [rab_pkg::POS_W-1:0]   lim;
    logic                        en;
    logic                        out_valid_reg;
    logic [rab_pkg::COUNT_W-1:0] set_count_reg;
    rab_pkg::beat_t              head;
    rab_pkg::beat_t              chain [rab_pkg::NUM_CELLS+1];

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_days_reg <= rab_pkg::NUM_DAYS_RESET;
        end
        else if (cfg_we)
        begin
            num_days_reg <= cfg_wdata;
        end
    end

    // chain moves whenever the output register can take a beat
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // clip the range at entry
    assign lim = (num_days_reg > rab_pkg::DAYS_POS) ? rab_pkg::DAYS_POS : num_days_reg;

    always_comb
    begin
        head.valid = in_valid;
        head.base  = '0;
        head.lo    = (range_low == '0) ? rab_pkg::FIRST_POS : range_low;
        head.hi    = (range_high > lim) ? lim : range_high;
        head.mode  = mode;
        head.lim   = lim;
        head.count = '0;
    end

    assign chain[0] = head;

    // cell chain
    for (genvar i = 0; i < rab_pkg::NUM_CELLS; i++)
    begin : g_cell
        rab_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .beat_in  (chain[i]),
            .beat_out (chain[i+1])
        );
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= chain[rab_pkg::NUM_CELLS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            set_count_reg <= chain[rab_pkg::NUM_CELLS].count;
        end
    end

    assign out_valid = out_valid_reg;
    assign set_count = set_count_reg;

    // a held chain keeps its last beat
    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(chain[rab_pkg::NUM_CELLS].valid) &&
                $stable(chain[rab_pkg::NUM_CELLS].count))
        else $error("cell chain moved while stalled");

    // count never exceeds the stored positions
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (set_count <= rab_pkg::COUNT_W'(rab_pkg::DAYS)))
        else $error("set count above position total");

    // config write lands
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (num_days_reg == $past(cfg_wdata)))
        else $error("num_days write lost");

endmodule

>>> bench/testbench.sv
// testbench for range_assign_bitmap_count: directed table and random range updates vs a predictor
`timescale 1ns / 100ps

module testbench;

    // range operations
    localparam logic MODE_CLEAR = 1'b0;
    localparam logic MODE_SET   = 1'b1;

    // a table row with no typed expectation takes the predictor's count
    localparam int NO_WANT          = -1;
    localparam int DRAIN_CYCLES     = rab_pkg::NUM_CELLS + 8;
    localparam int LIMIT_CYCLES     = 400000;
    localparam int RANDOM_PER_PHASE = 135;
    localparam int POS_MAX          = (1 << rab_pkg::POS_W) - 1;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_COMB} stall_mode_t;

    // for a config row the register value sits in lo
    typedef struct packed {
        row_kind_t                 kind;
        logic [rab_pkg::POS_W-1:0] lo;
        logic [rab_pkg::POS_W-1:0] hi;
        logic                      md;
        int                        want;
    } stim_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_we;
    logic [rab_pkg::POS_W-1:0]   cfg_wdata;
    logic                        in_valid;
    logic                        in_stall;
    logic [rab_pkg::POS_W-1:0]   range_low;
    logic [rab_pkg::POS_W-1:0]   range_high;
    logic                        mode;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [rab_pkg::COUNT_W-1:0] set_count;

    // predictor state
    logic                        day_bits [1:rab_pkg::DAYS];
    logic [rab_pkg::POS_W-1:0]   num_days_q;
    logic [rab_pkg::COUNT_W-1:0] count_expected [$];
    logic [rab_pkg::COUNT_W-1:0] count_head;

    stim_row_t   plan [$];
    int          fails = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    stall_mode_t stall_mode = STALL_NONE;

    range_assign_bitmap_count i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .range_low  (range_low),
        .range_high (range_high),
        .mode       (mode),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .set_count  (set_count)
    );

    always #5 clk = ~clk;

    // assign the clipped range, then count set positions up to the active limit
    function automatic logic [rab_pkg::COUNT_W-1:0] assign_and_count(
        input logic [rab_pkg::POS_W-1:0] lo,
        input logic [rab_pkg::POS_W-1:0] hi,
        input logic md);
        int unsigned lim;
        int unsigned first;
        int unsigned last;
        int unsigned total;
        lim   = (num_days_q > rab_pkg::DAYS) ? rab_pkg::DAYS : num_days_q;
        first = (lo < 1) ? 1 : lo;
        last  = (hi > lim) ? lim : hi;
        total = 0;
        for (int unsigned p = first; p <= last; p++)
            day_bits[p] = md;
        for (int unsigned p = 1; p <= lim; p++)
            total += day_bits[p];
        return rab_pkg::COUNT_W'(total);
    endfunction

    function automatic void add_row(input row_kind_t kind, input int lo, input int hi,
                                    input logic md, input int want);
        stim_row_t r;
        r.kind = kind;
        r.lo   = rab_pkg::POS_W'(lo);
        r.hi   = rab_pkg::POS_W'(hi);
        r.md   = md;
        r.want = want;
        plan.push_back(r);
    endfunction

    // drive one beat after the burst gap, hold it until taken, then predict
    task automatic send_range(input logic [rab_pkg::POS_W-1:0] lo,
                              input logic [rab_pkg::POS_W-1:0] hi,
                              input logic md, input int want);
        logic [rab_pkg::COUNT_W-1:0] predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        else
            gap_left = 0;
        @(negedge clk);
        if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_left) @(negedge clk);
        end
        range_low  <= lo;
        range_high <= hi;
        mode       <= md;
        in_valid   <= 1'b1;
        do @(posedge clk); while (in_stall);
        predicted = assign_and_count(lo, hi, md);
        count_expected.push_back((want >= 0) ? rab_pkg::COUNT_W'(want) : predicted);
        burst_left--;
    endtask

    // let every beat drain out of the cell chain
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (count_expected.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_days(input logic [rab_pkg::POS_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        num_days_q = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // receiver stall pattern, switching between randomly drawn stall modes
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
            default:     out_stall <= ((cycle_count % 4) == 0);
        endcase
    end

    // compare each result beat with the oldest expected count
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (count_expected.size() == 0)
            begin
                $error("set_count: no beat expected, actual %0d", set_count);
                fails++;
            end
            else
            begin
                count_head = count_expected.pop_front();
                if (set_count !== count_head)
                begin
                    $error("set_count: expected %0d, actual %0d", count_head, set_count);
                    fails++;
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        logic [rab_pkg::POS_W-1:0] phase_days [8];
        int                        lim;
        int                        lo_i;
        int                        hi_i;
        int                        sel;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        in_valid   = 1'b0;
        range_low  = '0;
        range_high = '0;
        mode       = MODE_CLEAR;
        foreach (day_bits[p])
            day_bits[p] = 1'b1;
        num_days_q = rab_pkg::NUM_DAYS_RESET;

        // directed rows, typed counts where they follow from the history above
        add_row(ROW_ITEM, 5, 3, MODE_SET, 1024);          // empty range
        add_row(ROW_ITEM, 0, 0, MODE_CLEAR, 1024);        // position zero only
        add_row(ROW_ITEM, 0, 1, MODE_CLEAR, 1023);        // zero start clips to one
        add_row(ROW_ITEM, 1, 1024, MODE_CLEAR, 0);
        add_row(ROW_ITEM, 1, 1024, MODE_SET, 1024);
        add_row(ROW_ITEM, 2047, 2047, MODE_CLEAR, 1024);  // wholly past the limit
        add_row(ROW_ITEM, 1000, 2047, MODE_CLEAR, 999);   // high end clipped
        add_row(ROW_ITEM, 0, 2047, MODE_SET, 1024);
        add_row(ROW_ITEM, 1024, 1024, MODE_CLEAR, 1023);
        add_row(ROW_ITEM, 1, 512, MODE_CLEAR, 511);
        add_row(ROW_CFG, 0, 0, MODE_CLEAR, NO_WANT);      // empty active set
        add_row(ROW_ITEM, 1, 1024, MODE_SET, 0);
        add_row(ROW_CFG, 2047, 0, MODE_CLEAR, NO_WANT);   // above DAYS acts as DAYS
        add_row(ROW_ITEM, 2047, 0, MODE_SET, 511);
        add_row(ROW_ITEM, 1024, 2047, MODE_SET, 512);
        add_row(ROW_CFG, 1, 0, MODE_CLEAR, NO_WANT);
        add_row(ROW_ITEM, 1, 1, MODE_SET, 1);
        add_row(ROW_ITEM, 2, 1024, MODE_SET, 1);
        add_row(ROW_CFG, 600, 0, MODE_CLEAR, NO_WANT);
        add_row(ROW_ITEM, 0, 2047, MODE_CLEAR, 0);
        add_row(ROW_CFG, 1024, 0, MODE_CLEAR, NO_WANT);   // upper bits kept their values
        add_row(ROW_ITEM, 700, 699, MODE_CLEAR, 424);
        add_row(ROW_ITEM, 300, 800, MODE_SET, NO_WANT);
        add_row(ROW_ITEM, 1023, 1024, MODE_CLEAR, NO_WANT);

        phase_days = '{11'd1024, 11'd1, 11'd2047, 11'd0, 11'd37, 11'd1023, 11'd1025,
                       rab_pkg::POS_W'($urandom_range(0, POS_MAX))};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_days(plan[i].lo);
            else
                send_range(plan[i].lo, plan[i].hi, plan[i].md, plan[i].want);
        end

        // random phases, mostly ranges inside the active span
        foreach (phase_days[ph])
        begin
            write_days(phase_days[ph]);
            lim = (num_days_q > rab_pkg::DAYS) ? rab_pkg::DAYS : num_days_q;
            repeat (RANDOM_PER_PHASE)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 60 && lim > 0)
                begin
                    lo_i = $urandom_range(1, lim);
                    if (sel < 30)
                        hi_i = lo_i + $urandom_range(0, 15);
                    else
                        hi_i = $urandom_range(lo_i, lim);
                    if (hi_i > lim)
                        hi_i = lim;
                end
                else if (sel < 75)
                begin
                    lo_i = $urandom_range(0, POS_MAX);
                    hi_i = $urandom_range(0, lo_i);
                end
                else
                begin
                    lo_i = $urandom_range(0, POS_MAX);
                    hi_i = $urandom_range(0, POS_MAX);
                end
                send_range(rab_pkg::POS_W'(lo_i), rab_pkg::POS_W'(hi_i),
                           logic'($urandom_range(0, 1)), NO_WANT);
            end
        end

        wait_idle();
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> range_assign_bitmap_count.f
rtl/rab_pkg.sv
rtl/rab_cell.sv
rtl/range_assign_bitmap_count.sv
bench/testbench.sv
